### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/lptw_pkg.sv
// types, codes and constants of the long-press toggle block
package lptw_pkg;

  localparam int unsigned LptW       = 16;
  localparam int unsigned WinW       = 20;
  localparam int unsigned PressAgeW  = 17;
  localparam int unsigned OpenAgeW   = 21;
  localparam int unsigned CfgDataW   = 20;

  localparam logic [PressAgeW-1:0] PRESS_AGE_MAX = '1;
  localparam logic [OpenAgeW-1:0]  OPEN_AGE_MAX  = '1;

  // 3000 ms and 600000 ms at a 20 ms poll period
  localparam logic [LptW-1:0] LPT_RESET = 16'd150;
  localparam logic [WinW-1:0] WIN_RESET = 20'd30000;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_TOGGLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_OPENED  = 2'd1,
    EV_CLOSED  = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_e;

  typedef enum logic {
    REG_LONG_PRESS = 1'b0,
    REG_WINDOW     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [WinW-1:0] window_ticks;
    logic [LptW-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic       button_down;
    logic [1:0] kind;
  } item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       is_open;
  } res_t;

endpackage

### rtl/core/lptw_cfg_regs.sv
// configuration registers: press threshold and window length
module lptw_cfg_regs
  import lptw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic                idx_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= LPT_RESET;
      cfg_q.window_ticks     <= WIN_RESET;
    end else if (we_i) begin
      case (idx_i)
        REG_LONG_PRESS: cfg_q.long_press_ticks <= wdata_i[LptW-1:0];
        REG_WINDOW:     cfg_q.window_ticks     <= wdata_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/lptw_update.sv
// press and window state with the per-request update logic
module lptw_update
  import lptw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic                 held_q, held_d;
  logic                 fired_q, fired_d;
  logic [PressAgeW-1:0] press_age_q, press_age_d;
  logic                 open_q, open_d;
  logic [OpenAgeW-1:0]  open_age_q, open_age_d;
  event_e               ev;

  always_comb begin
    held_d      = held_q;
    fired_d     = fired_q;
    press_age_d = press_age_q;
    open_d      = open_q;
    open_age_d  = open_age_q;
    ev          = EV_NONE;
    case (item_i.kind)
      KIND_TICK: begin
        if (open_q && open_age_q != OPEN_AGE_MAX) begin
          open_age_d = open_age_q + 1'b1;
        end
        if (item_i.button_down && !held_q) begin
          held_d      = 1'b1;
          fired_d     = 1'b0;
          press_age_d = '0;
        end else if (item_i.button_down) begin
          if (press_age_q != PRESS_AGE_MAX) begin
            press_age_d = press_age_q + 1'b1;
          end
          if (!fired_q && press_age_d > {1'b0, cfg_i.long_press_ticks}) begin
            fired_d = 1'b1;
            if (open_q) begin
              open_d = 1'b0;
              ev     = EV_CLOSED;
            end else begin
              open_d     = 1'b1;
              open_age_d = '0;
              ev         = EV_OPENED;
            end
          end
        end else begin
          held_d = 1'b0;
        end
        // a fresh open has age zero, so it never times out here
        if (open_d && open_age_d > {1'b0, cfg_i.window_ticks}) begin
          open_d = 1'b0;
          ev     = EV_TIMEOUT;
        end
      end
      KIND_OPEN: begin
        if (!open_q) begin
          open_d     = 1'b1;
          open_age_d = '0;
          ev         = EV_OPENED;
        end
      end
      KIND_TOGGLE: begin
        if (open_q) begin
          open_d = 1'b0;
          ev     = EV_CLOSED;
        end else begin
          open_d     = 1'b1;
          open_age_d = '0;
          ev         = EV_OPENED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      fired_q     <= 1'b0;
      press_age_q <= '0;
      open_q      <= 1'b0;
      open_age_q  <= '0;
    end else if (en_i) begin
      held_q      <= held_d;
      fired_q     <= fired_d;
      press_age_q <= press_age_d;
      open_q      <= open_d;
      open_age_q  <= open_age_d;
    end
  end

  assign res_o.is_open   = open_d;
  assign res_o.event_res = ev;

endmodule

### rtl/core/long_press_toggle_with_window.sv
// long-press toggle with auto-close window: top level with request and result registers
//
// s_axis carries one request per poll tick or external command; m_axis carries
// one result per request, in request order.
// a request accepted on s_axis sits in the input register, passes the combinational
// update step and is written to the result register once that register is free or
// its result is being taken; the result is offered from the result register.
// throughput is one request per cycle while m_axis_tready is high; all state updates
// finish in the single combinational step between the input and the result register.
// when m_axis_tready is low the result holds, the input register keeps its
// request, and s_axis_tready drops once both registers are full; nothing is
// lost and processing resumes on the cycle the result is taken.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i (index 0 long
// press threshold, index 1 window length); the user must write it only while the block
// is idle; the block does not enforce this. reset clears both valid flags, the press
// and window state, and reloads the thresholds to 150 and 30000 ticks.
module long_press_toggle_with_window
  import lptw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [1:0] kind, [2] button_down
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [0] is_open, [2:1] event_res
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

`include "assert_macros.svh"

  cfg_t  cfg;
  item_t in_q;
  logic  in_vld_q;
  res_t  res;
  res_t  out_q;
  logic  out_vld_q;
  logic  advance;

  lptw_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // move the held request into the result register
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  lptw_update u_update (
    .clk_i,
    .rst_ni,
    .en_i   (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= item_t'(s_axis_tdata[2:0]);
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q.event_res, out_q.is_open};

  `ASSERT_RST(a_full_stall_blocks, (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready, "request taken while both registers are full")
  `ASSERT_RST(a_open_event_flag, (advance && res.event_res == EV_OPENED) |-> res.is_open, "opened event without open flag")
  `ASSERT_RST(a_close_event_flag, (advance && (res.event_res == EV_CLOSED || res.event_res == EV_TIMEOUT)) |-> !res.is_open, "close event with open flag")
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!in_vld_q && !out_vld_q), "registers valid during reset")

endmodule

### dv/tb_long_press_toggle_with_window.sv
// self-checking testbench of the long-press toggle block with auto-close window
module tb_long_press_toggle_with_window;
  import lptw_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [1:0] kind, [2] button_down
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [0] is_open, [2:1] event_res
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = REG_LONG_PRESS;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  long_press_toggle_with_window dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t       req_q[$];
  res_t        flag_event_q[$];
  int unsigned err_cnt  = 0;
  int unsigned res_cnt  = 0;
  int unsigned pushed   = 0;

  // shadow of the block: thresholds, press tracking and window
  logic [LptW-1:0]      lpt_cfg     = LPT_RESET;
  logic [WinW-1:0]      win_cfg     = WIN_RESET;
  logic                 btn_held    = 1'b0;
  logic                 press_fired = 1'b0;
  logic [PressAgeW-1:0] press_cnt   = '0;
  logic                 win_open    = 1'b0;
  logic [OpenAgeW-1:0]  win_age     = '0;

  function automatic event_e open_window();
    if (win_open) return EV_NONE;
    win_open = 1'b1;
    win_age  = '0;
    return EV_OPENED;
  endfunction

  function automatic event_e flip_window();
    if (win_open) begin
      win_open = 1'b0;
      return EV_CLOSED;
    end
    return open_window();
  endfunction

  function automatic res_t next_flag_event(item_t it);
    event_e ev;
    res_t   r;
    ev = EV_NONE;
    case (it.kind)
      KIND_TICK: begin
        if (win_open && win_age != OPEN_AGE_MAX) win_age++;
        if (it.button_down && !btn_held) begin
          btn_held    = 1'b1;
          press_fired = 1'b0;
          press_cnt   = '0;
        end else if (it.button_down) begin
          if (press_cnt != PRESS_AGE_MAX) press_cnt++;
          if (!press_fired && press_cnt > lpt_cfg) begin
            press_fired = 1'b1;
            ev = flip_window();
          end
        end else begin
          btn_held = 1'b0;
        end
        if (win_open && win_age > win_cfg) begin
          win_open = 1'b0;
          ev = EV_TIMEOUT;
        end
      end
      KIND_OPEN:   ev = open_window();
      KIND_TOGGLE: ev = flip_window();
      default: ;
    endcase
    r.is_open   = win_open;
    r.event_res = ev;
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drive_req
    logic  vld_n;
    item_t it_n;
    if (rst_ni) begin
      vld_n = s_axis_tvalid;
      it_n  = item_t'(s_axis_tdata[2:0]);
      if (s_axis_tvalid && s_axis_tready) begin
        flag_event_q.push_back(next_flag_event(it_n));
        vld_n = 1'b0;
      end
      if (!vld_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          it_n  = req_q.pop_front();
          vld_n = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_axis_tvalid <= vld_n;
      s_axis_tdata  <= {5'b0, it_n};
    end
  end

  // receiver: checks results and stalls on a mode pattern of its own
  int unsigned rx_mode        = 0;
  int unsigned rx_phase       = 0;
  int unsigned hold_left      = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk_i) begin : take_res
    res_t got;
    res_t want;
    logic rdy;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[2:0]);
        res_cnt++;
        if (flag_event_q.size() == 0) begin
          $error("result with no request pending: is_open %0d event_res %0d",
                 got.is_open, got.event_res);
          err_cnt++;
        end else begin
          want = flag_event_q.pop_front();
          if (got.is_open !== want.is_open) begin
            $error("is_open: expected %0d, actual %0d", want.is_open, got.is_open);
            err_cnt++;
          end
          if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
            err_cnt++;
          end
        end
      end
      rx_phase++;
      if (rx_phase % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!long_hold_done && res_cnt >= 400) begin
        // long hold-off so the block fills and backs up the input
        long_hold_done = 1'b1;
        hold_left      = 150;
        rdy            = 1'b0;
      end else if ($urandom_range(0, 999) == 0) begin
        hold_left = $urandom_range(30, 100);
        rdy       = 1'b0;
      end else begin
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (rx_phase % 3 == 0);
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // watchdog on cycles with no handshake at all
  int unsigned idle_cyc = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IdleLimit) begin
      $display("[long_press_toggle_with_window] ERROR");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic push_req(kind_e kind, logic down);
    item_t it;
    it.kind        = kind;
    it.button_down = down;
    req_q.push_back(it);
    pushed++;
  endtask

  task automatic push_ticks(logic down, int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_req(KIND_TICK, down);
  endtask

  // checked away from the rising edge so driver and receiver updates have settled
  task automatic wait_drained();
    while (req_q.size() != 0 || s_axis_tvalid || flag_event_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_LONG_PRESS) lpt_cfg = val[LptW-1:0];
    else win_cfg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly press/release runs around the threshold, some requests and noise
  task automatic gen_mix(int unsigned n);
    int unsigned start;
    int unsigned dn_max;
    int unsigned up_max;
    int unsigned len;
    int unsigned r;
    start  = pushed;
    dn_max = (lpt_cfg + 3 > 60) ? 60 : lpt_cfg + 3;
    up_max = (win_cfg + 3 > 40) ? 40 : win_cfg + 3;
    while (pushed - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = $urandom_range(1, dn_max);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0)
            push_req(kind_e'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
          push_req(KIND_TICK, 1'b1);
        end
        len = $urandom_range(1, up_max);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0)
            push_req(kind_e'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
          push_req(KIND_TICK, 1'b0);
        end
      end else if (r < 85) begin
        push_req(kind_e'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 10);
        for (int unsigned i = 0; i < len; i++) push_req(KIND_TICK, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic run_phase(int unsigned lpt, int unsigned win, int unsigned n);
    wait_drained();
    write_reg(REG_LONG_PRESS, CfgDataW'(lpt));
    write_reg(REG_WINDOW, CfgDataW'(win));
    gen_mix(n);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // requests at reset thresholds
    push_req(KIND_TICK, 1'b0);
    push_req(KIND_OPEN, 1'b1);
    push_req(KIND_OPEN, 1'b0);
    push_req(kind_e'(2'd3), 1'b1);
    push_req(KIND_TOGGLE, 1'b0);
    push_req(KIND_TOGGLE, 1'b1);
    push_req(KIND_TICK, 1'b1);
    push_req(KIND_TICK, 1'b0);
    push_req(KIND_TOGGLE, 1'b0);
    push_req(kind_e'(2'd3), 1'b0);
    // one press just past the reset threshold
    push_ticks(1'b1, 155);
    push_ticks(1'b0, 3);

    // zero thresholds: fire on second down tick, close on first tick after open
    wait_drained();
    write_reg(REG_LONG_PRESS, '0);
    write_reg(REG_WINDOW, '0);
    push_ticks(1'b1, 3);
    push_req(KIND_TICK, 1'b0);
    push_req(KIND_OPEN, 1'b0);
    push_req(KIND_TICK, 1'b0);
    push_req(KIND_TICK, 1'b1);
    push_req(KIND_TOGGLE, 1'b0);
    push_req(KIND_TICK, 1'b1);
    push_req(KIND_TICK, 1'b0);
    push_req(KIND_OPEN, 1'b1);
    push_req(KIND_OPEN, 1'b0);
    push_req(kind_e'(2'd3), 1'b1);
    push_req(KIND_TICK, 1'b1);

    run_phase(0, 0, 150);
    run_phase(3, 10, 300);
    run_phase(1, 25, 300);
    run_phase(7, 4, 300);
    run_phase(65535, 1048575, 150);
    run_phase(2, 1048575, 200);
    run_phase(65535, 0, 150);
    run_phase(5, 60, 250);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (flag_event_q.size() != 0) begin
      $error("%0d expected results never arrived", flag_event_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("[long_press_toggle_with_window] OK");
    end else begin
      $display("[long_press_toggle_with_window] ERROR");
    end
    $finish;
  end

endmodule

### long_press_toggle_with_window.f
+incdir+rtl/core
rtl/core/lptw_pkg.sv
rtl/core/lptw_cfg_regs.sv
rtl/core/lptw_update.sv
rtl/core/long_press_toggle_with_window.sv
dv/tb_long_press_toggle_with_window.sv
